@@ rtl/core/osm_pkg.sv @@
// Shared types and constants for the order-statistic multiset.
`timescale 1ns / 1ps

package osm_pkg;

    // Datapath width of the shared adder: 32-bit operands plus sign and carry room
    localparam int DATA_W     = 34;
    localparam int ANS_W      = 32;
    localparam int VAL_W      = 32;
    localparam int RANK_W     = 16;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int DOMAIN_W   = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Word index of the window base register
    localparam logic REG_DOMAIN_LOW = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_RANK   = 3'd2,
        OP_KTH    = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5,
        OP_RANGE  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_OUT_WIN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

@@ rtl/core/osm_alu.sv @@
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
`timescale 1ns / 1ps

module osm_alu (
    input  logic [osm_pkg::DATA_W-1:0] a,
    input  logic [osm_pkg::DATA_W-1:0] b,
    input  logic                       sub,
    output logic [osm_pkg::DATA_W-1:0] y
);
    import osm_pkg::*;

    // a + b, or a - b as a + ~b + 1
    assign y = a + (b ^ {DATA_W{sub}}) + DATA_W'(sub);

endmodule

@@ rtl/core/osm_apb_regs.sv @@
// APB configuration register holding the window base.
`timescale 1ns / 1ps

module osm_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [osm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [osm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [osm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [osm_pkg::DOMAIN_W-1:0]   domain_low
);
    import osm_pkg::*;

    logic [DOMAIN_W-1:0] domain_low_reg;
    logic                sel_domain;

    assign pready     = 1'b1;
    assign sel_domain = (paddr[CFG_ADDR_W-1:2] == REG_DOMAIN_LOW);

    // write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_low_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_domain)
        begin
            domain_low_reg <= pwdata[DOMAIN_W-1:0];
        end
    end

    // read back, sign extended
    always_comb
    begin
        prdata = '0;
        if (sel_domain)
        begin
            prdata = {{(CFG_DATA_W-DOMAIN_W){domain_low_reg[DOMAIN_W-1]}}, domain_low_reg};
        end
    end

    assign domain_low = domain_low_reg;

endmodule

@@ rtl/core/order_statistic_multiset.sv @@
// Top level: count tree memory, sequencer and result register.
`timescale 1ns / 1ps

// Order-statistic multiset over the window [domain_low, domain_low + 2^VALUE_BITS - 1],
// kept as per-node counts of a complete binary tree in one single-port-read memory of
// 2^(VALUE_BITS+1) words. After reset the memory is swept to zero, one word a cycle;
// requests are held off meanwhile, configuration is taken as ever.
// One request is worked at a time and each tree level costs one memory read: insert/remove
// read and write back each node on the path, rank and k-th make one descent, and
// predecessor/successor and range count make two descents. An unused operation code is
// answered with status none. The window-base subtractions and the count sums and
// differences go through one shared adder. The result sits in an output register, so the next
// request is taken as soon as the previous one is finished, even if its result waits.
module order_statistic_multiset #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [osm_pkg::OP_W-1:0]       operation,
    input  logic signed [osm_pkg::VAL_W-1:0]  value,
    input  logic signed [osm_pkg::VAL_W-1:0]  range_high,
    input  logic [osm_pkg::RANK_W-1:0]     rank_index,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [osm_pkg::ANS_W-1:0]  answer,
    output logic [osm_pkg::STATUS_W-1:0]   status,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [osm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [osm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [osm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import osm_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int AW    = VALUE_BITS + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int W     = DATA_W;
    localparam int LVL_W = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OFFA,
        S_OFFB,
        S_DISPATCH,
        S_BELOW_START,
        S_BELOW,
        S_BELOW_END,
        S_CHECK,
        S_KTH_START,
        S_KTH,
        S_KADD,
        S_UPD_RD,
        S_UPD_WR,
        S_FIN
    } state_t;

    // configuration
    logic [DOMAIN_W-1:0] domain_low;

    osm_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .domain_low (domain_low)
    );

    // sequencer state
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [VAL_W-1:0]     hi_reg, hi_next;
    logic [W-1:0]         k_reg, k_next;
    logic [W-1:0]         off_a_reg, off_a_next;
    logic [W-1:0]         off_b_reg, off_b_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic                 acc_sub_reg, acc_sub_next;
    logic                 second_reg, second_next;
    logic [VB:0]          x_reg, x_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [ANS_W-1:0]     pend_ans_reg, pend_ans_next;
    status_t              pend_st_reg, pend_st_next;
    logic [ANS_W-1:0]     ans_reg, ans_next;
    status_t              st_reg, st_next;
    logic                 out_valid_reg, out_valid_next;

    // memory port
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic                  we;

    // shared adder
    logic [W-1:0] alu_a, alu_b, alu_y;
    logic         alu_sub;

    osm_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    // sign-extended operands; the memory word is zero-extended
    logic [W-1:0] dl_ext, val_ext, hi_ext, rd_ext;
    assign dl_ext  = {{(W-DOMAIN_W){domain_low[DOMAIN_W-1]}}, domain_low};
    assign val_ext = {{(W-VAL_W){val_reg[VAL_W-1]}}, val_reg};
    assign hi_ext  = {{(W-VAL_W){hi_reg[VAL_W-1]}}, hi_reg};
    assign rd_ext  = W'(rd_data_reg);

    // clipping of offsets into the window
    logic          a_neg, a_big, a_top, b_neg, b_big, range_empty;
    logic [VB-1:0] lo_c, hi_c;
    logic [VB:0]   leaves_x, clamp_rank, clamp_succ;

    assign leaves_x = {1'b1, {VB{1'b0}}};
    assign a_neg    = off_a_reg[W-1];
    assign a_big    = !a_neg && (off_a_reg[W-2:VB] != '0);
    assign a_top    = &off_a_reg[VB-1:0];
    assign b_neg    = off_b_reg[W-1];
    assign b_big    = !b_neg && (off_b_reg[W-2:VB] != '0);

    assign clamp_rank = a_neg ? '0 : (a_big ? leaves_x : {1'b0, off_a_reg[VB-1:0]});
    assign clamp_succ = a_neg ? '0 :
                        ((a_big || a_top) ? leaves_x
                                          : ({1'b0, off_a_reg[VB-1:0]} + (VB+1)'(1)));

    assign lo_c        = a_neg ? '0 : off_a_reg[VB-1:0];
    assign hi_c        = b_big ? '1 : off_b_reg[VB-1:0];
    assign range_empty = a_big || b_neg || (lo_c > hi_c);

    // descent decisions
    logic bit_now, kth_left, is_leaf;
    assign bit_now  = x_reg[VB-1];
    assign kth_left = alu_y[W-1] || (alu_y == '0);
    assign is_leaf  = node_reg[VB];

    // adder operand selection
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_OFFA:
            begin
                alu_a   = val_ext;
                alu_b   = dl_ext;
                alu_sub = 1'b1;
            end
            S_OFFB:
            begin
                alu_a   = hi_ext;
                alu_b   = dl_ext;
                alu_sub = 1'b1;
            end
            S_BELOW_START:
            begin
                alu_b   = W'(total_reg);
                alu_sub = acc_sub_reg;
            end
            S_BELOW:
            begin
                alu_b   = rd_ext;
                alu_sub = acc_sub_reg;
            end
            S_BELOW_END:
            begin
                alu_b = (op_reg == OP_PRED || op_reg == OP_RANGE) ? '0 : W'(1);
            end
            S_CHECK:
            begin
                alu_a   = W'(total_reg);
                alu_b   = k_reg;
                alu_sub = 1'b1;
            end
            S_KTH:
            begin
                alu_a   = k_reg;
                alu_b   = rd_ext;
                alu_sub = 1'b1;
            end
            S_KADD:
            begin
                alu_a = dl_ext;
                alu_b = W'(node_reg[VB-1:0]);
            end
            S_UPD_WR:
            begin
                alu_a   = rd_ext;
                alu_b   = W'(1);
                alu_sub = (op_reg == OP_REMOVE);
            end
            default:
            begin
                alu_a = acc_reg;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        off_a_next     = off_a_reg;
        off_b_next     = off_b_reg;
        acc_next       = acc_reg;
        acc_sub_next   = acc_sub_reg;
        second_next    = second_reg;
        x_next         = x_reg;
        node_next      = node_reg;
        lvl_next       = lvl_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        pend_ans_next  = pend_ans_reg;
        pend_st_next   = pend_st_reg;
        ans_next       = ans_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        raddr          = node_reg;
        waddr          = node_reg;
        wdata          = alu_y[COUNT_BITS-1:0];
        we             = 1'b0;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = op_t'(operation);
                    val_next      = value;
                    hi_next       = range_high;
                    k_next        = W'(rank_index);
                    pend_ans_next = '0;
                    pend_st_next  = ST_OK;
                    state_next    = S_OFFA;
                end
            end

            S_OFFA:
            begin
                off_a_next = alu_y;
                state_next = (op_reg == OP_RANGE) ? S_OFFB : S_DISPATCH;
            end

            S_OFFB:
            begin
                off_b_next = alu_y;
                state_next = S_DISPATCH;
            end

            S_DISPATCH:
            begin
                acc_next     = '0;
                acc_sub_next = 1'b0;
                second_next  = 1'b0;
                case (op_reg)
                    OP_INSERT, OP_REMOVE:
                    begin
                        if (a_neg || a_big)
                        begin
                            pend_st_next = ST_OUT_WIN;
                            state_next   = S_FIN;
                        end
                        else if (op_reg == OP_INSERT && total_reg == {COUNT_BITS{1'b1}})
                        begin
                            pend_st_next = ST_FULL;
                            state_next   = S_FIN;
                        end
                        else
                        begin
                            node_next  = {1'b1, off_a_reg[VB-1:0]};
                            state_next = S_UPD_RD;
                        end
                    end
                    OP_RANK, OP_PRED:
                    begin
                        x_next     = clamp_rank;
                        state_next = S_BELOW_START;
                    end
                    OP_SUCC:
                    begin
                        x_next     = clamp_succ;
                        state_next = S_BELOW_START;
                    end
                    OP_KTH:
                    begin
                        state_next = S_CHECK;
                    end
                    OP_RANGE:
                    begin
                        if (range_empty)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            x_next     = {1'b0, hi_c} + (VB+1)'(1);
                            state_next = S_BELOW_START;
                        end
                    end
                    default:
                    begin
                        pend_st_next = ST_NONE;
                        state_next   = S_FIN;
                    end
                endcase
            end

            // count below x: whole window short-cuts to the total
            S_BELOW_START:
            begin
                if (x_reg[VB])
                begin
                    acc_next   = alu_y;
                    state_next = S_BELOW_END;
                end
                else
                begin
                    raddr      = AW'(2);
                    node_next  = AW'(1);
                    lvl_next   = '0;
                    state_next = S_BELOW;
                end
            end

            // one level per cycle, left-child count read ahead
            S_BELOW:
            begin
                if (bit_now)
                begin
                    acc_next = alu_y;
                end
                node_next = {node_reg[VB-1:0], bit_now};
                raddr     = {node_next[VB-1:0], 1'b0};
                x_next    = x_reg << 1;
                lvl_next  = lvl_reg + LVL_W'(1);
                if (lvl_reg == LVL_W'(VB - 1))
                begin
                    state_next = S_BELOW_END;
                end
            end

            S_BELOW_END:
            begin
                case (op_reg)
                    OP_RANK:
                    begin
                        pend_ans_next = alu_y[ANS_W-1:0];
                        state_next    = S_FIN;
                    end
                    OP_PRED, OP_SUCC:
                    begin
                        k_next     = alu_y;
                        state_next = S_CHECK;
                    end
                    OP_RANGE:
                    begin
                        if (!second_reg)
                        begin
                            second_next  = 1'b1;
                            acc_sub_next = 1'b1;
                            x_next       = {1'b0, lo_c};
                            state_next   = S_BELOW_START;
                        end
                        else
                        begin
                            pend_ans_next = acc_reg[ANS_W-1:0];
                            state_next    = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // want must lie in 1..total
            S_CHECK:
            begin
                if (k_reg == '0 || alu_y[W-1])
                begin
                    pend_st_next = ST_NONE;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_KTH_START;
                end
            end

            S_KTH_START:
            begin
                raddr      = AW'(2);
                node_next  = AW'(1);
                lvl_next   = '0;
                state_next = S_KTH;
            end

            S_KTH:
            begin
                if (!kth_left)
                begin
                    k_next = alu_y;
                end
                node_next = {node_reg[VB-1:0], !kth_left};
                raddr     = {node_next[VB-1:0], 1'b0};
                lvl_next  = lvl_reg + LVL_W'(1);
                if (lvl_reg == LVL_W'(VB - 1))
                begin
                    state_next = S_KADD;
                end
            end

            S_KADD:
            begin
                pend_ans_next = alu_y[ANS_W-1:0];
                state_next    = S_FIN;
            end

            // leaf-to-root read-modify-write
            S_UPD_RD:
            begin
                raddr      = node_reg;
                state_next = S_UPD_WR;
            end

            S_UPD_WR:
            begin
                if (op_reg == OP_REMOVE && is_leaf && rd_data_reg == '0)
                begin
                    pend_st_next = ST_NONE;
                    state_next   = S_FIN;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = node_reg;
                    if (node_reg == AW'(1))
                    begin
                        total_next = alu_y[COUNT_BITS-1:0];
                        state_next = S_FIN;
                    end
                    else
                    begin
                        node_next  = node_reg >> 1;
                        state_next = S_UPD_RD;
                    end
                end
            end

            // hand over to the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ans_next       = pend_ans_reg;
                    st_next        = pend_st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_INSERT;
            val_reg       <= '0;
            hi_reg        <= '0;
            k_reg         <= '0;
            off_a_reg     <= '0;
            off_b_reg     <= '0;
            acc_reg       <= '0;
            acc_sub_reg   <= 1'b0;
            second_reg    <= 1'b0;
            x_reg         <= '0;
            node_reg      <= '0;
            lvl_reg       <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
            pend_ans_reg  <= '0;
            pend_st_reg   <= ST_OK;
            ans_reg       <= '0;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            hi_reg        <= hi_next;
            k_reg         <= k_next;
            off_a_reg     <= off_a_next;
            off_b_reg     <= off_b_next;
            acc_reg       <= acc_next;
            acc_sub_reg   <= acc_sub_next;
            second_reg    <= second_next;
            x_reg         <= x_next;
            node_reg      <= node_next;
            lvl_reg       <= lvl_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            pend_ans_reg  <= pend_ans_next;
            pend_st_reg   <= pend_st_next;
            ans_reg       <= ans_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // count tree memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = ans_reg;
    assign status    = st_reg;

endmodule

@@ rtl/core/osm_checker.sv @@
// Port-level checks on the order-statistic multiset, bound to the top level.
`timescale 1ns / 1ps

module osm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [osm_pkg::ANS_W-1:0]    answer,
    input logic [osm_pkg::STATUS_W-1:0] status
);
    import osm_pkg::*;

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one still in progress");

    // a result only appears at the end of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request being worked");

    // any failing status carries a zero answer
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_W'(ST_OK) |-> answer == '0)
        else $error("non-zero answer with failing status");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(status))
        else $error("result changed or dropped while stalled");

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .answer    (answer),
    .status    (status)
);
